>>> hdl/nearest_waypoint_ahead_search_top_assert.svh
// assertion macros for the nearest waypoint ahead search block
// used by nearest_waypoint_ahead_search_top, no other dependencies
`ifndef NEAREST_WAYPOINT_AHEAD_SEARCH_TOP_ASSERT_SVH
`define NEAREST_WAYPOINT_AHEAD_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NWAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nwas assertion failed");

// next-cycle implication
`define NWAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nwas assertion failed");

`else

`define NWAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define NWAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/nwas_pkg.sv
// shared constants, types and helper functions for the waypoint search
// no dependencies
`timescale 1ns / 1ps

package nwas_pkg;

    localparam int COORD_BITS = 24;
    localparam int PATH_DEPTH = 1024;
    localparam int INDEX_BITS = 10;

    // waypoints are interleaved over the lanes, lane = index mod N_CELLS (power of two)
    localparam int N_CELLS    = 4;
    localparam int CELL_W     = $clog2(N_CELLS);
    localparam int CNT_W      = $clog2(PATH_DEPTH + 1);
    localparam int WIDE_A     = $clog2(PATH_DEPTH + N_CELLS);
    localparam int WIDE_W     = (WIDE_A > INDEX_BITS + 1) ? WIDE_A : INDEX_BITS + 1;
    localparam int GRP_W      = WIDE_W - CELL_W;
    localparam int BANK_DEPTH = (PATH_DEPTH + N_CELLS - 1) / N_CELLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam int PT_W   = 2 * COORD_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DOT_W  = PROD_W + 1;

    // read, diff, square, update
    localparam int PIPE_LAT = 4;
    localparam int WAIT_CYC = PIPE_LAT + N_CELLS;
    localparam int WAIT_W   = $clog2(WAIT_CYC + 1);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_RESOLVE,
        ST_CHK_RD,
        ST_CHK_DIFF,
        ST_CHK_MUL,
        ST_CHK_SUM
    } state_t;

    typedef struct packed {
        logic               clear;
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [WIDE_W-1:0]  idx;
    } cell_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dsq;
        logic [WIDE_W-1:0] idx;
    } best_t;

    // a wins over b: smaller distance, lower index on a tie
    function automatic logic better(input best_t a, input best_t b);
        return a.valid && (!b.valid || (a.dsq < b.dsq) ||
                           ((a.dsq == b.dsq) && (a.idx < b.idx)));
    endfunction

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] s;
        s = v >> CELL_W;
        return s[BANK_AW-1:0];
    endfunction

    // magnitude of a difference of two coordinates always fits COORD_BITS
    function automatic logic [COORD_BITS-1:0] mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] a;
        a = d[DIFF_W-1] ? -d : d;
        return a[COORD_BITS-1:0];
    endfunction

endpackage

>>> hdl/nwas_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module nwas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/nwas_cell.sv
// one search lane: a bank of the path, a squared distance pipe, a local best
// and one stage of the merge chain; depends on nwas_pkg and nwas_ram
`timescale 1ns / 1ps

module nwas_cell
    import nwas_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctl_t                    ctl,
    input  logic                         we,
    input  logic [BANK_AW-1:0]           waddr,
    input  logic [PT_W-1:0]              wdata,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  best_t                        chain_in,
    output best_t                        chain_out,
    output logic [PT_W-1:0]              rd_pt
);

    logic [COORD_BITS-1:0]     rd_x;
    logic [COORD_BITS-1:0]     rd_y;
    logic                      s1_vld_reg;
    logic [WIDE_W-1:0]         s1_idx_reg;
    logic                      s2_vld_reg;
    logic [WIDE_W-1:0]         s2_idx_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dx_next;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic signed [DIFF_W-1:0]  dy_next;
    logic                      s3_vld_reg;
    logic [WIDE_W-1:0]         s3_idx_reg;
    logic [COORD_BITS-1:0]     mag_x;
    logic [COORD_BITS-1:0]     mag_y;
    logic [SQ_W-1:0]           sqx_reg;
    logic [SQ_W-1:0]           sqx_next;
    logic [SQ_W-1:0]           sqy_reg;
    logic [SQ_W-1:0]           sqy_next;
    best_t                     cand;
    best_t                     best_reg;
    best_t                     best_next;
    best_t                     chain_reg;
    best_t                     chain_next;

    nwas_ram #(
        .WIDTH (PT_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ctl.addr),
        .rdata (rd_pt)
    );

    assign rd_x = rd_pt[COORD_BITS-1:0];
    assign rd_y = rd_pt[PT_W-1:COORD_BITS];

    always_comb
    begin
        dx_next  = $signed({rd_x[COORD_BITS-1], rd_x}) - $signed({qx[COORD_BITS-1], qx});
        dy_next  = $signed({rd_y[COORD_BITS-1], rd_y}) - $signed({qy[COORD_BITS-1], qy});
        mag_x    = mag(dx_reg);
        mag_y    = mag(dy_reg);
        sqx_next = {{COORD_BITS{1'b0}}, mag_x} * {{COORD_BITS{1'b0}}, mag_x};
        sqy_next = {{COORD_BITS{1'b0}}, mag_y} * {{COORD_BITS{1'b0}}, mag_y};

        cand.valid = s3_vld_reg;
        cand.dsq   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        cand.idx   = s3_idx_reg;

        // strict compare keeps the first minimum of this lane
        if (ctl.clear)
        begin
            best_next = '0;
        end
        else if (cand.valid && (!best_reg.valid || (cand.dsq < best_reg.dsq)))
        begin
            best_next = cand;
        end
        else
        begin
            best_next = best_reg;
        end

        chain_next = better(best_reg, chain_in) ? best_reg : chain_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            best_reg   <= '0;
            chain_reg  <= '0;
        end
        else
        begin
            s1_vld_reg <= ctl.en;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            best_reg   <= best_next;
            chain_reg  <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= ctl.idx;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
    end

    assign chain_out = chain_reg;

endmodule

>>> hdl/nearest_waypoint_ahead_search_top.sv
// top level of the nearest waypoint ahead search; depends on nwas_pkg, nwas_cell
// and the assertion macro header
// append: no result, the next word may follow at once
// short path or start at or past its end: result in the cycle after the query is taken
// scan: G bank groups, G = last group - first group + 1 ~ (path_count - start) / 4
// the pass check, when run, follows the scan; one query at a time
// throughput bounded by one read per lane bank per cycle; results cannot be stalled
// reset clears the point count and control state, path contents undefined until written
`timescale 1ns / 1ps
`include "nearest_waypoint_ahead_search_top_assert.svh"

module nearest_waypoint_ahead_search_top
    import nwas_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic                         restart,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic [INDEX_BITS-1:0]        start_index,
    output logic                         done,
    output logic [INDEX_BITS-1:0]        next_index
);

    // control state
    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [WAIT_W-1:0]        wait_reg;
    logic [WAIT_W-1:0]        wait_next;
    logic                     done_reg;
    logic                     done_next;

    // query payload
    logic signed [COORD_BITS-1:0] qx_reg;
    logic signed [COORD_BITS-1:0] qx_next;
    logic signed [COORD_BITS-1:0] qy_reg;
    logic signed [COORD_BITS-1:0] qy_next;
    logic [WIDE_W-1:0]        qstart_reg;
    logic [WIDE_W-1:0]        qstart_next;
    logic [GRP_W-1:0]         grp_reg;
    logic [GRP_W-1:0]         grp_next;
    logic [GRP_W-1:0]         last_grp_reg;
    logic [GRP_W-1:0]         last_grp_next;
    logic [WIDE_W-1:0]        best_idx_reg;
    logic [WIDE_W-1:0]        best_idx_next;
    logic [INDEX_BITS-1:0]    result_reg;
    logic [INDEX_BITS-1:0]    result_next;

    // pass check datapath
    logic signed [DIFF_W-1:0] v1x_reg;
    logic signed [DIFF_W-1:0] v1x_next;
    logic signed [DIFF_W-1:0] v1y_reg;
    logic signed [DIFF_W-1:0] v1y_next;
    logic signed [DIFF_W-1:0] v2x_reg;
    logic signed [DIFF_W-1:0] v2x_next;
    logic signed [DIFF_W-1:0] v2y_reg;
    logic signed [DIFF_W-1:0] v2y_next;
    logic signed [PROD_W-1:0] prx_reg;
    logic signed [PROD_W-1:0] prx_next;
    logic signed [PROD_W-1:0] pry_reg;
    logic signed [PROD_W-1:0] pry_next;
    logic                     nz1_reg;
    logic                     nz1_next;
    logic                     nz2_reg;
    logic                     nz2_next;
    logic signed [DOT_W-1:0]  dot;
    logic                     advance;

    // lane interface
    logic                     accept;
    logic                     wr_en;
    logic [WIDE_W-1:0]        wr_idx;
    logic [WIDE_W-1:0]        count_w;
    logic [WIDE_W-1:0]        cnt_m1;
    logic [WIDE_W-1:0]        start_w;
    logic [WIDE_W-1:0]        nxt_idx;
    logic [PT_W-1:0]          cpt;
    logic [PT_W-1:0]          npt;
    cell_ctl_t                cell_ctl [N_CELLS];
    logic [PT_W-1:0]          rd_pt    [N_CELLS];
    best_t                    chain    [N_CELLS+1];

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign count_w = WIDE_W'(count_reg);
    assign cnt_m1  = count_w - 1'b1;
    assign start_w = WIDE_W'(start_index);
    assign nxt_idx = best_idx_reg + 1'b1;

    // closest point and the one after it come from two different lanes
    assign cpt = rd_pt[best_idx_reg[CELL_W-1:0]];
    assign npt = rd_pt[nxt_idx[CELL_W-1:0]];

    assign dot     = $signed({prx_reg[PROD_W-1], prx_reg}) + $signed({pry_reg[PROD_W-1], pry_reg});
    // advance when the position lies on the far side of the closest point,
    // i.e. (pos - closest) and (next - closest) are non-zero and their dot product is non-negative
    assign advance = nz1_reg && nz2_reg && !dot[DOT_W-1];

    // merge chain enters empty at lane zero
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N_CELLS; g++)
        begin : g_lane
            logic lane_we;

            assign lane_we = wr_en && (wr_idx[CELL_W-1:0] == CELL_W'(g));

            nwas_cell u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl[g]),
                .we        (lane_we),
                .waddr     (bank_addr(wr_idx)),
                .wdata     ({pos_y, pos_x}),
                .qx        (qx_reg),
                .qy        (qy_reg),
                .chain_in  (chain[g]),
                .chain_out (chain[g+1]),
                .rd_pt     (rd_pt[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        wait_next     = wait_reg;
        done_next     = 1'b0;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        qstart_next   = qstart_reg;
        grp_next      = grp_reg;
        last_grp_next = last_grp_reg;
        best_idx_next = best_idx_reg;
        result_next   = result_reg;
        v1x_next      = v1x_reg;
        v1y_next      = v1y_reg;
        v2x_next      = v2x_reg;
        v2y_next      = v2y_reg;
        prx_next      = prx_reg;
        pry_next      = pry_reg;
        nz1_next      = nz1_reg;
        nz2_next      = nz2_reg;
        wr_en         = 1'b0;
        wr_idx        = '0;
        for (int k = 0; k < N_CELLS; k++)
        begin
            cell_ctl[k] = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_APPEND))
                begin
                    // a full path drops further points until a restart
                    if (restart)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = '0;
                        count_next = CNT_W'(1);
                    end
                    else if (count_reg < CNT_W'(PATH_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = count_w;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (accept)
                begin
                    qx_next     = pos_x;
                    qy_next     = pos_y;
                    qstart_next = start_w;
                    if (count_reg < CNT_W'(2))
                    begin
                        // path too short to search
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else if (start_w >= count_w)
                    begin
                        // nothing to scan, start index comes back as is
                        done_next   = 1'b1;
                        result_next = start_index;
                    end
                    else
                    begin
                        grp_next      = start_w[WIDE_W-1:CELL_W];
                        last_grp_next = cnt_m1[WIDE_W-1:CELL_W];
                        state_next    = ST_SCAN;
                        for (int k = 0; k < N_CELLS; k++)
                        begin
                            cell_ctl[k].clear = 1'b1;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // one group of N_CELLS consecutive waypoints per cycle
                for (int k = 0; k < N_CELLS; k++)
                begin
                    cell_ctl[k].idx  = {grp_reg, CELL_W'(k)};
                    cell_ctl[k].addr = grp_reg[BANK_AW-1:0];
                    cell_ctl[k].en   = (cell_ctl[k].idx >= qstart_reg) &&
                                       (cell_ctl[k].idx < count_w);
                end
                if (grp_reg == last_grp_reg)
                begin
                    wait_next  = WAIT_W'(WAIT_CYC);
                    state_next = ST_WAIT;
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end

            ST_WAIT:
            begin
                // drain the distance pipes, then let the merge run down the chain
                if (wait_reg == '0)
                begin
                    state_next = ST_RESOLVE;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end

            ST_RESOLVE:
            begin
                best_idx_next = chain[N_CELLS].idx;
                if ((chain[N_CELLS].idx + WIDE_W'(2)) < count_w)
                begin
                    state_next = ST_CHK_RD;
                end
                else
                begin
                    // closest point is one of the last two, no pass check
                    done_next   = 1'b1;
                    result_next = chain[N_CELLS].idx[INDEX_BITS-1:0];
                    state_next  = ST_IDLE;
                end
            end

            ST_CHK_RD:
            begin
                for (int k = 0; k < N_CELLS; k++)
                begin
                    cell_ctl[k].addr = (best_idx_reg[CELL_W-1:0] == CELL_W'(k)) ?
                                       bank_addr(best_idx_reg) : bank_addr(nxt_idx);
                end
                state_next = ST_CHK_DIFF;
            end

            ST_CHK_DIFF:
            begin
                v1x_next   = $signed({qx_reg[COORD_BITS-1], qx_reg}) -
                             $signed({cpt[COORD_BITS-1], cpt[COORD_BITS-1:0]});
                v1y_next   = $signed({qy_reg[COORD_BITS-1], qy_reg}) -
                             $signed({cpt[PT_W-1], cpt[PT_W-1:COORD_BITS]});
                v2x_next   = $signed({npt[COORD_BITS-1], npt[COORD_BITS-1:0]}) -
                             $signed({cpt[COORD_BITS-1], cpt[COORD_BITS-1:0]});
                v2y_next   = $signed({npt[PT_W-1], npt[PT_W-1:COORD_BITS]}) -
                             $signed({cpt[PT_W-1], cpt[PT_W-1:COORD_BITS]});
                state_next = ST_CHK_MUL;
            end

            ST_CHK_MUL:
            begin
                prx_next   = v1x_reg * v2x_reg;
                pry_next   = v1y_reg * v2y_reg;
                nz1_next   = (v1x_reg != '0) || (v1y_reg != '0);
                nz2_next   = (v2x_reg != '0) || (v2y_reg != '0);
                state_next = ST_CHK_SUM;
            end

            ST_CHK_SUM:
            begin
                best_idx_next = best_idx_reg + WIDE_W'(advance);
                result_next   = best_idx_next[INDEX_BITS-1:0];
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            wait_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        qstart_reg   <= qstart_next;
        grp_reg      <= grp_next;
        last_grp_reg <= last_grp_next;
        best_idx_reg <= best_idx_next;
        result_reg   <= result_next;
        v1x_reg      <= v1x_next;
        v1y_reg      <= v1y_next;
        v2x_reg      <= v2x_next;
        v2y_reg      <= v2y_next;
        prx_reg      <= prx_next;
        pry_reg      <= pry_next;
        nz1_reg      <= nz1_next;
        nz2_reg      <= nz2_next;
    end

    assign done       = done_reg;
    assign next_index = result_reg;

    // a result word only ever shows up while the block is free again
    `NWAS_ASSERT_IMPLY(a_done_not_busy, clk, rst_n, done, !busy)
    // point count never runs past the path depth
    `NWAS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(PATH_DEPTH))
    // an append word never starts a search
    `NWAS_ASSERT_NEXT(a_append_idle, clk, rst_n, accept && (op == OP_APPEND), !busy && !done)
    // a scan always leaves a winner at the end of the merge chain
    `NWAS_ASSERT_IMPLY(a_merge_valid, clk, rst_n, state_reg == ST_RESOLVE, chain[N_CELLS].valid)

endmodule
